### rtl/core/fpmt_pkg.sv
// fpmt_pkg: shared types and constants for the prefix-minimum Fenwick table.
// No dependencies.
`timescale 1ns / 1ps

package fpmt_pkg;

  localparam int RANK_W  = 11;
  localparam int VALUE_W = 64;
  localparam int OP_W    = 2;
  localparam int IN_TDATA_W = ((RANK_W + VALUE_W + 7) / 8) * 8;

  localparam logic [VALUE_W-1:0] SENTINEL = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [RANK_W-1:0]  RANKS_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_LOWER = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

endpackage

### rtl/core/fenwick_prefix_min_table.sv
// fenwick_prefix_min_table: Fenwick tree of signed prefix minima, one memory.
// Depends on fpmt_pkg.
// Lower/query: the request is accepted, then the walk visits the nodes in turn
// (at most $clog2(MAX_RANKS+1) nodes, one read of the node memory per cycle);
// a query then loads the output register, waiting in ST_EMIT while a result is stalled.
// Clear: one node written per cycle over all MAX_RANKS nodes, s_tready low.
// Reset (rst, synchronous) runs the same clearing pass;
// ranks_in_use resets to 1024 and cfg writes are taken throughout.
`timescale 1ns / 1ps

module fenwick_prefix_min_table
  import fpmt_pkg::*;
#(
  parameter int MAX_RANKS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // rank[10:0], value[74:11], zero fill
  input  logic [OP_W-1:0]       s_tuser,   // op[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VALUE_W-1:0]    m_tdata,   // prefix_minimum[63:0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RANK_W-1:0]     cfg_data   // ranks_in_use[10:0]
);

  localparam int IW = $clog2(MAX_RANKS + 1);
  localparam int WW = IW + 1;
  localparam int AW = $clog2(MAX_RANKS);
  localparam int CW = ((IW > RANK_W) ? IW : RANK_W) + 1;

  logic [VALUE_W-1:0] mem [MAX_RANKS];
  logic [VALUE_W-1:0] rdata;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               wr_en;

  state_t             state, state_next;
  logic [WW-1:0]      cur, cur_next;
  logic [VALUE_W-1:0] best, best_next;
  logic [VALUE_W-1:0] val;
  logic               is_query;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic [RANK_W-1:0]  ranks_in_use;
  logic               load_out;

  logic               accept;
  logic [RANK_W-1:0]  in_rank;
  logic [CW-1:0]      bound_cw, rank_cw, rank_eff;
  logic [WW-1:0]      bound_w, lowbit, nxt_up, nxt_down;
  logic [VALUE_W-1:0] cand;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign in_rank   = s_tdata[RANK_W-1:0];

  always_comb begin
    bound_cw = (CW'(ranks_in_use) > CW'(MAX_RANKS)) ? CW'(MAX_RANKS) : CW'(ranks_in_use);
    rank_cw  = CW'(in_rank);
    rank_eff = (rank_cw > bound_cw) ? bound_cw : rank_cw;
    bound_w  = WW'(bound_cw);
    lowbit   = cur & (~cur + WW'(1));
    nxt_up   = cur + lowbit;
    nxt_down = cur & (cur - WW'(1));
    cand     = ($signed(rdata) < $signed(best)) ? rdata : best;
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    best_next     = best;
    clr_addr_next = clr_addr;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = AW'(cur - WW'(1));
    wr_data       = val;
    load_out      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = SENTINEL;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_RANKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        best_next = SENTINEL;
        if (accept) begin
          unique case (s_tuser)
            OP_LOWER: begin
              if (rank_cw != '0 && rank_cw <= bound_cw) begin
                cur_next   = WW'(rank_cw);
                rd_addr    = AW'(rank_cw - CW'(1));
                state_next = ST_WALK;
              end
            end
            OP_QUERY: begin
              if (rank_eff != '0) begin
                cur_next   = WW'(rank_eff);
                rd_addr    = AW'(rank_eff - CW'(1));
                state_next = ST_WALK;
              end else begin
                state_next = ST_EMIT;
              end
            end
            OP_CLEAR: begin
              clr_addr_next = '0;
              state_next    = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (is_query) begin
          best_next = cand;
          if (nxt_down != '0) begin
            cur_next = nxt_down;
            rd_addr  = AW'(nxt_down - WW'(1));
          end else begin
            state_next = ST_EMIT;
          end
        end else begin
          wr_en = ($signed(val) < $signed(rdata));
          if (nxt_up <= bound_w) begin
            cur_next = nxt_up;
            rd_addr  = AW'(nxt_up - WW'(1));
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    cur  <= cur_next;
    best <= best_next;
    if (accept) begin
      val      <= s_tdata[RANK_W +: VALUE_W];
      is_query <= (s_tuser == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ranks_in_use <= RANKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ranks_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= best;
    end
  end

endmodule

### rtl/core/fpmt_checker.sv
// fpmt_checker: port-level assertions for fenwick_prefix_min_table, and its bind.
// Depends on fpmt_pkg.
`timescale 1ns / 1ps

module fpmt_checker
  import fpmt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [OP_W-1:0]       s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [VALUE_W-1:0]    m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("ready during reset clearing pass");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
    else $error("query request did not occupy the block");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_CLEAR |=> !s_tready)
    else $error("clear request did not start clearing pass");

  // lower requests never produce a result
  a_lower_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_LOWER |=> !$rose(m_tvalid))
    else $error("result after lower request");

endmodule

bind fenwick_prefix_min_table fpmt_checker u_fpmt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
